### hw/rtl/fbal_pkg.sv
// Shared types and constants for the first-fit block allocator.
// Field widths, block kind codes, register indexes and sequencer states.
// No dependencies.
package fbal_pkg;

   localparam int REQ_W      = 24;
   localparam int ADDR_W     = 32;
   localparam int FIRST_W    = 10;
   localparam int TAKEN_W    = 11;
   localparam int BYTES_W    = 15;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam int ALIGN_MASK = 7;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_FREE = 2'd0;
   localparam kind_type KIND_HEAD = 2'd1;
   localparam kind_type KIND_TAIL = 2'd2;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_POOL_BASE  = 1'b0;
   localparam csr_index_type CSR_MAX_BLOCKS = 1'b1;

   localparam logic [ADDR_W-1:0]  POOL_BASE_RESET  = 32'h9000_0000;
   localparam logic [TAKEN_W-1:0] MAX_BLOCKS_RESET = 11'd1024;
   localparam logic [BYTES_W-1:0] BYTES_MAX        = 15'h7FFF;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_CHECK,
      ST_SCAN,
      ST_MARK,
      ST_FINISH
   } state_type;

endpackage

### hw/rtl/fbal_const_div.sv
// Division by a fixed divisor through a reciprocal multiply; the quotient is registered in the cycle after start.
// Turns a byte count into a block count for the allocator; no package use.
module fbal_const_div #(
   parameter int DIVIDEND_W = 25,
   parameter int DIVISOR    = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int SHIFT_C = DIVIDEND_W + $clog2(DIVISOR);
   localparam int RECIP_W = DIVIDEND_W + 1;
   localparam int PROD_W  = DIVIDEND_W + RECIP_W;
   localparam logic [63:0] RECIP_L =
      ((64'd1 << SHIFT_C) + 64'(DIVISOR - 1)) / 64'(DIVISOR);
   localparam logic [RECIP_W-1:0] RECIP_C = RECIP_L[RECIP_W-1:0];

   logic              done_ff;
   logic [PROD_W-1:0] prod_ff, prod_in;

   assign prod_in = PROD_W'(dividend) * PROD_W'(RECIP_C);

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= prod_in;
      end
   end

   assign done     = done_ff;
   assign quotient = DIVIDEND_W'(prod_ff >> SHIFT_C);

endmodule

### hw/rtl/first_fit_block_allocator_unit.sv
// First-fit block allocator: top level with block kind table and sequencer.
// Depends on fbal_pkg and fbal_const_div.
//
// Usage. A word on the req_ channel carries a byte count. It is rounded up to
// whole blocks of BLOCK_BYTES bytes and then to a multiple of eight blocks.
// If that exceeds max_blocks_per_request, or no run of free blocks is long
// enough, the rsp_ word has granted low and zero address fields. Otherwise
// the first fitting run from block 0 is marked and its address returned.
// The csr_ port writes pool_base (index 0) and max_blocks_per_request
// (index 1); write only while no request is in flight.
// After reset the table is cleared one entry a cycle, with req_stall high.
// One request at a time, taken only while idle. From acceptance to rsp_valid
// a request passes through rounding (reciprocal multiply), the limit check,
// a table scan up to the end of the fitting run (single registered read
// port), marking of the run (at least one block) and the load of the output
// register; a request over the limit skips the scan and the marking. The
// next word is taken in the cycle after the result is loaded. A finished
// word waits in the output register while rsp_stall is high; the next
// request may be taken and worked on meanwhile, and holds in its last step
// until the output is free.
module first_fit_block_allocator_unit #(
   parameter int NUM_BLOCKS  = 1024,
   parameter int BLOCK_BYTES = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [fbal_pkg::REQ_W-1:0]           req_request_bytes,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_granted,
   output logic [fbal_pkg::ADDR_W-1:0]          rsp_block_address,
   output logic [fbal_pkg::FIRST_W-1:0]         rsp_first_block,
   output logic [fbal_pkg::TAKEN_W-1:0]         rsp_blocks_taken,
   output logic [fbal_pkg::BYTES_W-1:0]         rsp_bytes_in_use,
   input  logic                                 csr_write_enable,
   input  fbal_pkg::csr_index_type              csr_index,
   input  logic [fbal_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   import fbal_pkg::*;

   localparam int IDX_W  = $clog2(NUM_BLOCKS);
   localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
   localparam int Q_W    = REQ_W + 1;
   localparam int NBLK_W = Q_W + 1;

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       clr_idx_ff, clr_idx_in;
   logic [NBLK_W-1:0]      nblk_ff, nblk_in;
   logic [CNT_W-1:0]       scan_idx_ff, scan_idx_in;
   logic                   pipe_valid_ff, pipe_valid_in;
   logic [IDX_W-1:0]       pipe_idx_ff, pipe_idx_in;
   logic [CNT_W-1:0]       run_ff, run_in;
   logic [CNT_W-1:0]       run_new;
   logic [IDX_W-1:0]       start_ff, start_in;
   logic [CNT_W-1:0]       mark_cnt_ff, mark_cnt_in;
   logic                   found_ff, found_in;
   logic [31:0]            grant_ff, grant_in;
   logic [BYTES_W-1:0]     alloc_ff, alloc_in;
   logic [31:0]            life_ff, life_in;
   logic [31:0]            bytes_add;
   logic [31:0]            bytes_sum;
   logic [ADDR_W-1:0]      base_ff;
   logic [TAKEN_W-1:0]     max_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_granted_ff, rsp_granted_in;
   logic [ADDR_W-1:0]      rsp_addr_ff, rsp_addr_in;
   logic [FIRST_W-1:0]     rsp_first_ff, rsp_first_in;
   logic [TAKEN_W-1:0]     rsp_taken_ff, rsp_taken_in;
   logic [BYTES_W-1:0]     rsp_bytes_ff, rsp_bytes_in;

   kind_type               kind_mem [NUM_BLOCKS];
   kind_type               rd_data_ff;
   logic [IDX_W-1:0]       rd_addr;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   kind_type               mem_wdata;

   logic                   div_start;
   logic                   div_done;
   logic [Q_W-1:0]         div_quotient;
   logic [Q_W-1:0]         div_dividend;

   fbal_const_div #(
      .DIVIDEND_W (Q_W),
      .DIVISOR    (BLOCK_BYTES)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign div_dividend = Q_W'(req_request_bytes) + Q_W'(BLOCK_BYTES - 1);
   assign rd_addr      = scan_idx_ff[IDX_W-1:0];
   assign run_new      = run_ff + CNT_W'(1);
   assign bytes_add    = 32'(nblk_ff) * 32'(BLOCK_BYTES);
   assign bytes_sum    = 32'(alloc_ff) + bytes_add;

   always_comb begin
      state_in       = state_ff;
      clr_idx_in     = clr_idx_ff;
      nblk_in        = nblk_ff;
      scan_idx_in    = scan_idx_ff;
      pipe_valid_in  = pipe_valid_ff;
      pipe_idx_in    = pipe_idx_ff;
      run_in         = run_ff;
      start_in       = start_ff;
      mark_cnt_in    = mark_cnt_ff;
      found_in       = found_ff;
      grant_in       = grant_ff;
      alloc_in       = alloc_ff;
      life_in        = life_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_granted_in = rsp_granted_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_first_in   = rsp_first_ff;
      rsp_taken_in   = rsp_taken_ff;
      rsp_bytes_in   = rsp_bytes_ff;
      div_start      = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = clr_idx_ff;
      mem_wdata      = KIND_FREE;
      req_stall      = 1'b1;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            clr_idx_in = clr_idx_ff + IDX_W'(1);
            if (32'(clr_idx_ff) == 32'(NUM_BLOCKS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               nblk_in  = (NBLK_W'(div_quotient) + NBLK_W'(ALIGN_MASK))
                          & ~NBLK_W'(ALIGN_MASK);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (nblk_ff <= NBLK_W'(max_ff)) begin
               scan_idx_in   = '0;
               pipe_valid_in = 1'b0;
               run_in        = '0;
               start_in      = '0;
               state_in      = ST_SCAN;
            end else begin
               found_in = 1'b0;
               state_in = ST_FINISH;
            end
         end
         ST_SCAN: begin
            pipe_valid_in = 1'b0;
            if (32'(scan_idx_ff) < 32'(NUM_BLOCKS)) begin
               pipe_valid_in = 1'b1;
               pipe_idx_in   = rd_addr;
               scan_idx_in   = scan_idx_ff + CNT_W'(1);
            end
            if (pipe_valid_ff) begin
               if (rd_data_ff == KIND_FREE) begin
                  run_in = run_new;
                  if (run_ff == '0) begin
                     start_in = pipe_idx_ff;
                  end
                  if (32'(run_new) >= 32'(nblk_ff)) begin
                     mark_cnt_in = '0;
                     state_in    = ST_MARK;
                  end
               end else begin
                  run_in = '0;
               end
            end else if (32'(scan_idx_ff) == 32'(NUM_BLOCKS)) begin
               found_in = 1'b0;
               state_in = ST_FINISH;
            end
         end
         ST_MARK: begin
            mem_we      = 1'b1;
            mem_waddr   = start_ff + IDX_W'(mark_cnt_ff);
            mem_wdata   = (mark_cnt_ff == '0) ? KIND_HEAD : KIND_TAIL;
            mark_cnt_in = mark_cnt_ff + CNT_W'(1);
            if (32'(mark_cnt_ff) + 32'd1 >= 32'(nblk_ff)) begin
               found_in = 1'b1;
               grant_in = grant_ff + 32'd1;
               life_in  = life_ff + bytes_add;
               alloc_in = (bytes_sum > 32'(BYTES_MAX)) ? BYTES_MAX
                                                       : bytes_sum[BYTES_W-1:0];
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = found_ff;
               rsp_bytes_in   = alloc_ff;
               if (found_ff) begin
                  rsp_addr_in  = base_ff + 32'(start_ff) * 32'(BLOCK_BYTES);
                  rsp_first_in = FIRST_W'(32'(start_ff));
                  rsp_taken_in = nblk_ff[TAKEN_W-1:0];
               end else begin
                  rsp_addr_in  = '0;
                  rsp_first_in = '0;
                  rsp_taken_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_idx_ff    <= '0;
         pipe_valid_ff <= 1'b0;
         found_ff      <= 1'b0;
         grant_ff      <= '0;
         alloc_ff      <= '0;
         life_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_idx_ff    <= clr_idx_in;
         pipe_valid_ff <= pipe_valid_in;
         found_ff      <= found_in;
         grant_ff      <= grant_in;
         alloc_ff      <= alloc_in;
         life_ff       <= life_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nblk_ff        <= nblk_in;
      scan_idx_ff    <= scan_idx_in;
      pipe_idx_ff    <= pipe_idx_in;
      run_ff         <= run_in;
      start_ff       <= start_in;
      mark_cnt_ff    <= mark_cnt_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_first_ff   <= rsp_first_in;
      rsp_taken_ff   <= rsp_taken_in;
      rsp_bytes_ff   <= rsp_bytes_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= POOL_BASE_RESET;
         max_ff  <= MAX_BLOCKS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_POOL_BASE:  base_ff <= csr_write_data[ADDR_W-1:0];
            CSR_MAX_BLOCKS: max_ff  <= csr_write_data[TAKEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         kind_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= kind_mem[rd_addr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted       = rsp_granted_ff;
   assign rsp_block_address = rsp_addr_ff;
   assign rsp_first_block   = rsp_first_ff;
   assign rsp_blocks_taken  = rsp_taken_ff;
   assign rsp_bytes_in_use  = rsp_bytes_ff;

   a_mark_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MARK |->
         32'(start_ff) + 32'(mark_cnt_ff) < 32'(NUM_BLOCKS)
         && 32'(mark_cnt_ff) < 32'(nblk_ff) + 32'd1)
      else $error("table mark outside the pool or past the run");

   a_grant_within_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_granted_ff |-> 32'(rsp_taken_ff) <= 32'(max_ff))
      else $error("granted run exceeds the per-request limit");

   a_fail_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_granted_ff |->
         rsp_addr_ff == '0 && rsp_first_ff == '0 && rsp_taken_ff == '0)
      else $error("refused word carries a nonzero address field");

   a_div_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside the divide step");

endmodule
